// ===== hdl/bbc_pkg.sv =====
// Shared types and constants for the brace balance checker.
package bbc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CHAR_OPEN      = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE     = 8'h7D;
  localparam logic [7:0] CHAR_HASH      = 8'h23;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE    = 8'h22;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_UNMATCHED = 2'd0,
    KIND_UNCLOSED  = 2'd1,
    KIND_OVERFLOW  = 2'd2,
    KIND_DONE      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_LEFT,
    CELL_LOAD_RIGHT,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

  typedef struct packed {
    logic        occ;
    logic [15:0] line;
    logic [15:0] col;
  } cell_t;

  localparam cell_t CELL_EMPTY = '{occ: 1'b0, line: 16'd0, col: 16'd0};

  typedef enum logic {
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

// ===== hdl/bbc_if.sv =====
// Valid/ready channel interfaces for source bytes and reports.
interface bbc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_mark;

  modport source (output valid, text_byte, end_mark, input ready);
  modport sink   (input valid, text_byte, end_mark, output ready);
endinterface

interface bbc_report_if;
  logic        valid;
  logic        ready;
  logic [1:0]  report_kind;
  logic [15:0] line_no;
  logic [15:0] column_no;
  logic        source_valid;
  logic        run_last;

  modport source (output valid, report_kind, line_no, column_no, source_valid, run_last,
                  input ready);
  modport sink   (input valid, report_kind, line_no, column_no, source_valid, run_last,
                  output ready);
endinterface

// ===== hdl/brace_balance_checker.sv =====
// A reporting byte shows its registered report in the cycle after the request is taken.
// Throughput: one byte per cycle while reports are taken; one cell row shifts per cycle.
// End of source: the flush shifts the cell row toward its far end and reports the open
// braces bottom first as each reaches the tail, then the done report.
// Reset: synchronous rst clears lexer state, counters, level and cell valid flags;
// brace positions in the cells are not cleared.
module brace_balance_checker (
  input  logic                clk,
  input  logic                rst,
  bbc_text_if.sink            text_in,
  bbc_report_if.source        report_out
);

  localparam int LW = bbc_pkg::LEVEL_W;

  bbc_pkg::state_t state, state_next;
  logic [LW-1:0]   level, remain;
  logic            any_report;

  logic        out_valid;
  logic [1:0]  out_kind;
  logic [15:0] out_line, out_col;
  logic        out_src_valid, out_last;

  logic        live;
  logic [15:0] cur_line, cur_col;

  logic out_free, acc, byte_acc, end_acc;
  logic is_open, is_close, full, empty;
  logic push, pop, overflow, unmatched;
  logic emit_open, flush_shift, emit_done;

  bbc_pkg::cell_t     row [bbc_pkg::STACK_DEPTH];
  bbc_pkg::cell_t     head_in;
  bbc_pkg::cell_ctl_t ctl;
  bbc_pkg::cell_t     tail;

  assign out_free = !out_valid || report_out.ready;
  assign text_in.ready = (state == bbc_pkg::ST_SCAN) && out_free;
  assign acc      = text_in.valid && text_in.ready;
  assign byte_acc = acc && !text_in.end_mark;
  assign end_acc  = acc && text_in.end_mark;

  assign is_open  = text_in.text_byte == bbc_pkg::CHAR_OPEN;
  assign is_close = text_in.text_byte == bbc_pkg::CHAR_CLOSE;
  assign full     = level == LW'(bbc_pkg::STACK_DEPTH);
  assign empty    = level == '0;

  assign push      = byte_acc && live && is_open && !full;
  assign overflow  = byte_acc && live && is_open && full;
  assign pop       = byte_acc && live && is_close && !empty;
  assign unmatched = byte_acc && live && is_close && empty;

  assign tail = row[bbc_pkg::STACK_DEPTH-1];

  always_comb begin
    emit_open   = 1'b0;
    flush_shift = 1'b0;
    emit_done   = 1'b0;
    if (state == bbc_pkg::ST_FLUSH) begin
      if (remain != '0) begin
        emit_open   = tail.occ && out_free;
        flush_shift = !tail.occ || out_free;
      end else begin
        emit_done = out_free;
      end
    end
  end

  bbc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (byte_acc),
    .clear     (emit_done),
    .text_byte (text_in.text_byte),
    .live      (live),
    .line      (cur_line),
    .col       (cur_col)
  );

  // Push and flush both shift toward the far end; pop shifts back toward the head.
  always_comb begin
    head_in = bbc_pkg::CELL_EMPTY;
    if (push) begin
      head_in = '{occ: 1'b1, line: cur_line, col: cur_col};
    end
    priority if (emit_done) begin
      ctl.op = bbc_pkg::CELL_CLEAR;
    end else if (push || flush_shift) begin
      ctl.op = bbc_pkg::CELL_LOAD_LEFT;
    end else if (pop) begin
      ctl.op = bbc_pkg::CELL_LOAD_RIGHT;
    end else begin
      ctl.op = bbc_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < bbc_pkg::STACK_DEPTH; i++) begin : g_cell
    bbc_pkg::cell_t left_in, right_in;
    if (i == 0) begin : g_head
      assign left_in = head_in;
    end else begin : g_mid_l
      assign left_in = row[i-1];
    end
    if (i == bbc_pkg::STACK_DEPTH - 1) begin : g_tail
      assign right_in = bbc_pkg::CELL_EMPTY;
    end else begin : g_mid_r
      assign right_in = row[i+1];
    end
    bbc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .left_in  (left_in),
      .right_in (right_in),
      .q        (row[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bbc_pkg::ST_SCAN:  if (end_acc) state_next = bbc_pkg::ST_FLUSH;
      bbc_pkg::ST_FLUSH: if (emit_done) state_next = bbc_pkg::ST_SCAN;
      default:           state_next = bbc_pkg::ST_SCAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bbc_pkg::ST_SCAN;
      level      <= '0;
      remain     <= '0;
      any_report <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_done) begin
        level      <= '0;
        any_report <= 1'b0;
      end else begin
        if (push) level <= level + LW'(1);
        if (pop)  level <= level - LW'(1);
        if (overflow || unmatched) any_report <= 1'b1;
      end
      if (end_acc) begin
        remain <= level;
      end else if (emit_open) begin
        remain <= remain - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= overflow || unmatched || emit_open || emit_done;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      priority if (emit_done) begin
        out_kind      <= bbc_pkg::KIND_DONE;
        out_line      <= 16'd0;
        out_col       <= 16'd0;
        out_src_valid <= !any_report && empty;
        out_last      <= 1'b1;
      end else if (emit_open) begin
        out_kind      <= bbc_pkg::KIND_UNCLOSED;
        out_line      <= tail.line;
        out_col       <= tail.col;
        out_src_valid <= 1'b0;
        out_last      <= 1'b0;
      end else if (overflow) begin
        out_kind      <= bbc_pkg::KIND_OVERFLOW;
        out_line      <= cur_line;
        out_col       <= cur_col;
        out_src_valid <= 1'b0;
        out_last      <= 1'b1;
      end else begin
        out_kind      <= bbc_pkg::KIND_UNMATCHED;
        out_line      <= cur_line;
        out_col       <= cur_col;
        out_src_valid <= 1'b0;
        out_last      <= 1'b1;
      end
    end
  end

  assign report_out.valid        = out_valid;
  assign report_out.report_kind  = out_kind;
  assign report_out.line_no      = out_line;
  assign report_out.column_no    = out_col;
  assign report_out.source_valid = out_src_valid;
  assign report_out.run_last     = out_last;

endmodule

// ===== hdl/bbc_cell.sv =====
// One stack cell: holds a brace position and trades it with its neighbors.
module bbc_cell (
  input  logic              clk,
  input  logic              rst,
  input  bbc_pkg::cell_ctl_t ctl,
  input  bbc_pkg::cell_t    left_in,
  input  bbc_pkg::cell_t    right_in,
  output bbc_pkg::cell_t    q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.occ <= 1'b0;
    end else begin
      unique case (ctl.op)
        bbc_pkg::CELL_HOLD:       q.occ <= q.occ;
        bbc_pkg::CELL_LOAD_LEFT:  q.occ <= left_in.occ;
        bbc_pkg::CELL_LOAD_RIGHT: q.occ <= right_in.occ;
        bbc_pkg::CELL_CLEAR:      q.occ <= 1'b0;
        default:                  q.occ <= q.occ;
      endcase
    end
    unique case (ctl.op)
      bbc_pkg::CELL_LOAD_LEFT: begin
        q.line <= left_in.line;
        q.col  <= left_in.col;
      end
      bbc_pkg::CELL_LOAD_RIGHT: begin
        q.line <= right_in.line;
        q.col  <= right_in.col;
      end
      default: begin
        q.line <= q.line;
        q.col  <= q.col;
      end
    endcase
  end

endmodule

// ===== hdl/bbc_scan.sv =====
// Lexer state: quotes, escapes, line comments and line/column counters.
module bbc_scan (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        clear,
  input  logic [7:0]  text_byte,
  output logic        live,
  output logic [15:0] line,
  output logic [15:0] col
);

  logic in_sq, in_dq, esc, in_cmt;
  logic in_sq_next, in_dq_next, esc_next, in_cmt_next;
  logic [15:0] line_next, col_next;
  logic in_str;

  assign in_str = in_sq | in_dq;
  assign live   = !in_str && !in_cmt;

  always_comb begin
    in_sq_next  = in_sq;
    in_dq_next  = in_dq;
    esc_next    = esc;
    in_cmt_next = in_cmt;
    line_next   = line;
    col_next    = col;
    if (text_byte == bbc_pkg::CHAR_HASH && !in_str) begin
      in_cmt_next = 1'b1;
    end
    if (text_byte == bbc_pkg::CHAR_NEWLINE) begin
      in_cmt_next = 1'b0;
    end
    priority if (esc) begin
      esc_next = 1'b0;
    end else if (text_byte == bbc_pkg::CHAR_BACKSLASH) begin
      esc_next = 1'b1;
    end else if (text_byte == bbc_pkg::CHAR_SQUOTE && !in_dq) begin
      in_sq_next = !in_sq;
    end else if (text_byte == bbc_pkg::CHAR_DQUOTE && !in_sq) begin
      in_dq_next = !in_dq;
    end
    // saturate both counters
    if (text_byte == bbc_pkg::CHAR_NEWLINE) begin
      if (line != bbc_pkg::POS_MAX) begin
        line_next = line + 16'd1;
      end
      col_next = 16'd1;
    end else if (col != bbc_pkg::POS_MAX) begin
      col_next = col + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      in_sq  <= 1'b0;
      in_dq  <= 1'b0;
      esc    <= 1'b0;
      in_cmt <= 1'b0;
      line   <= 16'd1;
      col    <= 16'd1;
    end else if (step) begin
      in_sq  <= in_sq_next;
      in_dq  <= in_dq_next;
      esc    <= esc_next;
      in_cmt <= in_cmt_next;
      line   <= line_next;
      col    <= col_next;
    end
  end

endmodule

// ===== hdl/bbc_checker.sv =====
// Port-level assertions for the brace balance checker, bound to the top level.
module bbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] line,
  input logic [15:0] col,
  input logic        src_valid,
  input logic        run_last
);

  // hold a stalled report
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(line) && $stable(col))
    else $error("stalled report changed");

  // flush after an end request blocks the next request
  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_end |=> !in_ready)
    else $error("request taken right after end of source");

  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while report stalled");

  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == bbc_pkg::KIND_DONE |-> run_last && line == 16'd0 && col == 16'd0)
    else $error("malformed done report");

  a_other_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != bbc_pkg::KIND_DONE |-> !src_valid && line != 16'd0 && col != 16'd0)
    else $error("malformed brace report");

endmodule

bind brace_balance_checker bbc_checker u_bbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text_in.valid),
  .in_ready  (text_in.ready),
  .in_end    (text_in.end_mark),
  .out_valid (report_out.valid),
  .out_ready (report_out.ready),
  .kind      (report_out.report_kind),
  .line      (report_out.line_no),
  .col       (report_out.column_no),
  .src_valid (report_out.source_valid),
  .run_last  (report_out.run_last)
);
